// File: sv/esp_pkg.sv
// Shared types and constants for the encoder speed sampler.
// Holds the controller state encoding and the command and status structs.
// No dependencies.
`default_nettype none

package esp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_REVERSE = 2'd0;
	localparam logic [1:0] REG_COUNTS_PER_TURN = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_SAMPLE_RATE = 2'd3;

	// Register reset values.
	localparam logic [15:0] CPT_RESET = 16'd1024;
	localparam logic [15:0] PERIOD_RESET = 16'd20;
	localparam logic [9:0] SPS_RESET = 10'd50;

	// Divider geometry: a 50-bit dividend retired two quotient bits a cycle.
	localparam int DVD_BITS = 50;
	localparam int DIV_STEPS = DVD_BITS / 2;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	// Saturation limits of the velocity output.
	localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VEL_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} esp_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic mul;
		logic div_step;
		logic finish;
	} esp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sample;
		logic div_last;
		logic out_free;
	} esp_status_t;

endpackage

`default_nettype wire

// File: sv/esp_ctrl.sv
// Controller state machine of the encoder speed sampler.
// Sequences sample, multiply, divide and result hand-over; uses esp_pkg.
`default_nettype none

module esp_ctrl
	import esp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire esp_status_t status,
	output esp_cmd_t         cmd
);

	esp_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.sample) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/esp_datapath.sv
// Datapath of the encoder speed sampler: registers, tick divider, step and
// position, velocity multiply, radix-4 restoring divider and output register.
// Uses esp_pkg; driven by esp_ctrl.
`default_nettype none

module esp_datapath
	import esp_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic [31:0] count,
	input  wire esp_cmd_t    cmd,
	output esp_status_t      status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] step_counts,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity_q8
);

	localparam int SHIFT = 32 - COUNTER_BITS;

	logic        reverse_q;
	logic [15:0] cpt_q;
	logic [15:0] period_q;
	logic [9:0]  sps_q;

	logic [15:0] tick_q;
	logic [31:0] last_q;
	logic [31:0] pos_q;
	logic [31:0] step_q;
	logic        neg_q;
	logic [DVD_BITS-1:0] dvd_q;
	logic [15:0] rem_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic        out_valid_q;
	logic [31:0] out_step_q;
	logic [31:0] out_pos_q;
	logic [31:0] out_vel_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
			cpt_q <= CPT_RESET;
			period_q <= PERIOD_RESET;
			sps_q <= SPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REVERSE: reverse_q <= cfg_data[0];
				REG_COUNTS_PER_TURN: cpt_q <= cfg_data;
				REG_PERIOD: period_q <= cfg_data;
				REG_SAMPLE_RATE: sps_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Tick divider and the sample decision.
	logic [15:0] tick_next;
	assign tick_next = tick_q + 16'd1;
	assign status.sample = tick_next > period_q;

	// Wrapped step, sign-extended from the counter width.
	logic [31:0] diff;
	logic [31:0] step_new;
	assign diff = count - last_q;
	assign step_new = 32'($signed(diff << SHIFT) >>> SHIFT);

	// Magnitude of the step for the velocity product.
	logic [31:0] mag;
	logic [41:0] prod;
	assign mag = step_q[31] ? (32'd0 - step_q) : step_q;
	assign prod = {10'd0, mag} * {32'd0, sps_q};

	// Two restoring division steps per cycle; a zero divisor counts as one.
	logic [15:0] divisor;
	logic [16:0] r1, r2;
	logic        ge1, ge2;
	logic [15:0] r1s, r2s;
	assign divisor = (cpt_q == 16'd0) ? 16'd1 : cpt_q;
	always_comb begin
		r1 = {rem_q, dvd_q[DVD_BITS-1]};
		ge1 = r1 >= {1'b0, divisor};
		r1s = ge1 ? 16'(r1 - {1'b0, divisor}) : r1[15:0];
		r2 = {r1s, dvd_q[DVD_BITS-2]};
		ge2 = r2 >= {1'b0, divisor};
		r2s = ge2 ? 16'(r2 - {1'b0, divisor}) : r2[15:0];
	end
	assign status.div_last = cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1);

	// Control state of the datapath: tick divider, sampled count, position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			last_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (status.sample) begin
					tick_q <= '0;
					last_q <= count;
					pos_q <= pos_q + step_new;
				end else begin
					tick_q <= tick_next;
				end
			end
			if (cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
			end
		end
	end

	// Working registers of one sample request.
	always_ff @(posedge clk) begin
		if (cmd.accept && status.sample) begin
			step_q <= step_new;
		end
		if (cmd.mul) begin
			neg_q <= step_q[31] ^ reverse_q;
			dvd_q <= {prod, 8'd0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_BITS-3:0], ge1, ge2};
			rem_q <= r2s;
		end
	end

	// Saturation of the quotient to the signed 32-bit range.
	logic [31:0] vel;
	always_comb begin
		if (neg_q) begin
			if ((|dvd_q[DVD_BITS-1:32]) || (dvd_q[31] && (|dvd_q[30:0]))) begin
				vel = VEL_MIN;
			end else begin
				vel = 32'd0 - dvd_q[31:0];
			end
		end else begin
			if (|dvd_q[DVD_BITS-1:31]) begin
				vel = VEL_MAX;
			end else begin
				vel = dvd_q[31:0];
			end
		end
	end

	// Output register: holds a result until it is taken.
	assign status.out_free = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_step_q <= step_q;
			out_pos_q <= pos_q;
			out_vel_q <= vel;
		end
	end

	assign out_valid = out_valid_q;
	assign step_counts = $signed(out_step_q);
	assign position = $signed(out_pos_q);
	assign velocity_q8 = $signed(out_vel_q);

endmodule

`default_nettype wire

// File: sv/encoder_speed_sampler_top.sv
// Encoder speed sampler: one tick request per accepted count. A tick that
// takes no sample leaves the controller idle. A sample tick gives its result
// after a multiply state, the divider state at two quotient bits per step and a
// hand-over state, and waits longer while an untaken result holds the output
// register. The next request is taken only after the result is registered.
// Active-low asynchronous reset restores defaults.
`default_nettype none

module encoder_speed_sampler_top
	import esp_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] step_counts,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity_q8
);

	esp_cmd_t    cmd;
	esp_status_t status;

	// Sequencer.
	esp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	esp_datapath #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.count       (count),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.step_counts (step_counts),
		.position    (position),
		.velocity_q8 (velocity_q8)
	);

endmodule

`default_nettype wire

// File: dv/encoder_speed_sampler_checker.sv
// Checker for the encoder speed sampler: follows register writes, predicts the
// sample that each accepted tick request produces and compares every accepted result.
// Depends on esp_pkg for the register indexes and the register reset values.
module encoder_speed_sampler_checker
	import esp_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        count,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] step_counts,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity_q8,
	output int                 failures,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic [31:0] step;
		logic [31:0] pos;
		logic [31:0] vel;
	} speed_sample_t;

	// Shadow copy of the registers and of the sampler state.
	logic          reverse_q;
	logic [15:0]   cpt_q;
	logic [15:0]   period_q;
	logic [9:0]    sps_q;
	logic [15:0]   divider_q;
	logic [31:0]   last_count_q;
	logic [31:0]   position_q;
	speed_sample_t samples_due[$];
	int            fail_tally = 0;

	assign failures = fail_tally;

	// Difference of two counts modulo 2^COUNTER_BITS, sign-extended.
	function automatic logic signed [63:0] wrapped_diff(input logic [31:0] now,
			input logic [31:0] prev);
		logic [63:0] span;
		logic [63:0] d;
		span = 64'd1 << COUNTER_BITS;
		d = ({32'd0, now} - {32'd0, prev}) & (span - 64'd1);
		if ((d & (span >> 1)) != 64'd0)
			return $signed(d) - $signed(span);
		return $signed(d);
	endfunction

	// Turns per second in Q.8, truncated towards zero and saturated.
	function automatic logic [31:0] velocity_of_step(input logic signed [63:0] diff);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] divisor;
		logic [63:0] q;
		neg = diff < 0;
		mag = neg ? 64'(-diff) : 64'(diff);
		divisor = (cpt_q == 16'd0) ? 64'd1 : {48'd0, cpt_q};
		if (reverse_q)
			neg = ~neg;
		q = (mag * {54'd0, sps_q} * 64'd256) / divisor;
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'd0 - q[31:0];
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_tally < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_tally++;
	endtask

	// One tick: advance the divider and queue a sample when it passes the period.
	task automatic predict_tick(input logic [31:0] now);
		logic signed [63:0] diff;
		speed_sample_t      s;
		divider_q = divider_q + 16'd1;
		if (divider_q <= period_q)
			return;
		divider_q = '0;
		diff = wrapped_diff(now, last_count_q);
		last_count_q = now;
		position_q = position_q + diff[31:0];
		s.step = diff[31:0];
		s.pos = position_q;
		s.vel = velocity_of_step(diff);
		samples_due.push_back(s);
	endtask

	task automatic check_result();
		speed_sample_t want;
		if (samples_due.size() == 0) begin
			report_mismatch($sformatf("result with no sample due: step %0d position %0d velocity %0d",
				step_counts, position, velocity_q8));
			return;
		end
		want = samples_due.pop_front();
		if (step_counts !== want.step)
			report_mismatch($sformatf("step_counts %0d, expected %0d",
				step_counts, $signed(want.step)));
		if (position !== want.pos)
			report_mismatch($sformatf("position %0d, expected %0d",
				position, $signed(want.pos)));
		if (velocity_q8 !== want.vel)
			report_mismatch($sformatf("velocity_q8 %0d, expected %0d",
				velocity_q8, $signed(want.vel)));
	endtask

	// Register writes first, then the tick request, then the result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q = 1'b0;
			cpt_q = CPT_RESET;
			period_q = PERIOD_RESET;
			sps_q = SPS_RESET;
			divider_q = '0;
			last_count_q = '0;
			position_q = '0;
			samples_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REVERSE: reverse_q = cfg_data[0];
					REG_COUNTS_PER_TURN: cpt_q = cfg_data;
					REG_PERIOD: period_q = cfg_data;
					REG_SAMPLE_RATE: sps_q = cfg_data[9:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_tick(count);
			if (out_valid && out_ready)
				check_result();
			outstanding <= samples_due.size();
		end
	end

endmodule

// File: dv/encoder_speed_sampler_top_test.sv
// Testbench top for the encoder speed sampler: clock, reset, register settings,
// tick requests, receiver back-pressure and the final verdict.
// Depends on esp_pkg, encoder_speed_sampler_top and encoder_speed_sampler_checker.
module encoder_speed_sampler_top_test
	import esp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNTER_BITS = 32;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_TICKS = 130;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int LONG_PERIOD_TICKS = 40;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_RARELY,
		RX_PATTERN
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [31:0]        count;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] step_counts;
	logic signed [31:0] position;
	logic signed [31:0] velocity_q8;
	int                 failures;
	int                 outstanding;

	int          cycle_count = 0;
	logic [31:0] enc_count = '0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	logic        hold_off_req = 1'b0;

	encoder_speed_sampler_top #(
		.COUNTER_BITS(COUNTER_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.count(count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_counts(step_counts),
		.position(position),
		.velocity_q8(velocity_q8)
	);

	encoder_speed_sampler_checker #(
		.COUNTER_BITS(COUNTER_BITS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.count(count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_counts(step_counts),
		.position(position),
		.velocity_q8(velocity_q8),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: stalls on its own changing pattern, with one long hold-off on request.
	initial begin : receiver
		rx_mode_t    rx_mode;
		logic [31:0] rx_cycle;
		logic        hold_seen;
		int          hold_left;
		rx_mode = RX_ALWAYS;
		rx_cycle = '0;
		hold_seen = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle[7:0] == 8'd0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_off_req != hold_seen) begin
				hold_seen = hold_off_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (rx_cycle[2:0] != 3'd0) && (rx_cycle[4:3] != 2'd3);
				endcase
			end
		end
	end

	// Encoder-like movement, with the odd jump to an arbitrary value or a half turn.
	function automatic logic [31:0] walk_count(input logic [31:0] c);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return c + $urandom_range(0, 400) - 32'd200;
			6, 7: return c + $urandom_range(0, 131072) - 32'd65536;
			8: return $urandom();
			default: begin
				case ($urandom_range(0, 2))
					0: return c + 32'h7FFF_FFFF;
					1: return c + 32'h8000_0000;
					default: return c + 32'h8000_0001;
				endcase
			end
		endcase
	endfunction

	// Offer one tick request in bursts with random gaps; returns at the accepting edge.
	task automatic send_tick(input logic [31:0] v);
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		count <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_step(input logic [31:0] delta);
		enc_count = enc_count + delta;
		send_tick(enc_count);
	endtask

	// Drain every pending result and let the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [15:0] rev_d, input logic [15:0] cpt_d,
			input logic [15:0] per_d, input logic [15:0] sps_d);
		logic [1:0]  idx[4];
		logic [15:0] val[4];
		idx = '{REG_REVERSE, REG_COUNTS_PER_TURN, REG_PERIOD, REG_SAMPLE_RATE};
		val = '{rev_d, cpt_d, per_d, sps_d};
		settle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] rev_d;
		logic [15:0] cpt_d;
		logic [15:0] per_d;
		logic [15:0] sps_d;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: the twenty-first tick takes the first sample.
		for (int k = 0; k < 21; k++)
			send_step(32'd37);

		// Unit divisor at full rate: zero, unit and extreme steps, saturating both ways.
		apply_setting(16'd0, 16'd1, 16'd0, 16'd1023);
		send_step(32'd0);
		send_step(32'd1);
		send_step(32'hFFFF_FFFF);
		send_step(32'h7FFF_FFFF);
		send_step(32'h8000_0000);
		send_step(32'h0080_0000);

		// Zero divisor, reversed, high bits of the register data dropped; the
		// quotient lands exactly on two to the thirty-first.
		apply_setting(16'hFFFF, 16'd0, 16'd0, 16'hFC01);
		send_step(32'h0080_0000);
		send_step(32'hFF80_0000);
		send_step(32'hFFFF_FFFB);

		// Zero sample rate gives zero velocity; every second tick samples.
		apply_setting(16'd0, 16'hFFFF, 16'd1, 16'hFC00);
		send_step(32'd3);
		send_step(32'd9);
		send_step(32'd100);
		send_step(32'd200);

		// Truncation towards zero with the largest divisor.
		apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd1);
		send_step(32'd255);
		send_step(32'hFFFF_FED4);

		// Random settings, each with a run of encoder-like ticks.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			rev_d = 16'($urandom);
			case ($urandom_range(0, 7))
				0: cpt_d = 16'd0;
				1, 2: cpt_d = 16'($urandom_range(1, 16));
				default: cpt_d = 16'($urandom_range(1, 65535));
			endcase
			per_d = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 40))
				: 16'($urandom_range(0, 3));
			sps_d = {6'($urandom), 10'($urandom_range(0, 1023))};
			if (ph == 0) begin
				rev_d = 16'd0;
				cpt_d = 16'hFFFF;
				per_d = 16'd0;
				sps_d = 16'd1000;
			end
			if (ph == 1) begin
				rev_d = 16'd1;
				cpt_d = 16'd1;
				per_d = 16'd1;
				sps_d = 16'd1;
			end
			// Every tick samples while the receiver holds off, so the block fills up.
			if (ph == 2)
				per_d = 16'd0;
			apply_setting(rev_d, cpt_d, per_d, sps_d);
			gaps_on = (ph % 3) != 1;
			if (ph == 2)
				hold_off_req <= ~hold_off_req;
			for (int k = 0; k < PHASE_TICKS; k++) begin
				// Halfway through some phases the sender waits for every result.
				if (k == PHASE_TICKS / 2 && ph % 4 == 1) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (outstanding != 0) @(posedge clk);
				end
				enc_count = walk_count(enc_count);
				send_tick(enc_count);
			end
		end

		// Largest period: no sample while the divider climbs; after a shorter
		// period is set, the high divider makes the very next tick sample.
		apply_setting(16'd0, 16'd1024, 16'hFFFF, 16'd50);
		gaps_on = 1'b0;
		for (int k = 0; k < LONG_PERIOD_TICKS; k++) begin
			enc_count = walk_count(enc_count);
			send_tick(enc_count);
		end
		apply_setting(16'd0, 16'd1024, 16'd2, 16'd50);
		gaps_on = 1'b1;
		for (int k = 0; k < 12; k++)
			send_step(32'd5);

		settle();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
